// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL of the closest point block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TCP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TCP_ASSERT(lbl, clk, rstn, prop, msg)
`define TCP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: hdl/tcp_pkg.sv
`timescale 1ns / 1ps
package tcp_pkg;

  localparam int CW  = 32;         // coordinate width
  localparam int DW  = CW + 1;     // coordinate difference width
  localparam int PW  = 2 * DW;     // product of two differences
  localparam int SW  = PW + 4;     // sums and differences of products
  localparam int NW  = PW + 2;     // unsigned numerator and denominator
  localparam int MW  = CW;         // magnitude of an edge component
  localparam int KW  = 23;         // numerator chunk for partial products
  localparam int NCH = 3;          // number of numerator chunks
  localparam int PPW = KW + MW;    // partial product width
  localparam int DVW = NW + MW + 2; // dividend and remainder width
  localparam int QW  = MW;         // quotient width

  localparam logic [2:0] REG_A  = 3'd0;
  localparam logic [2:0] REG_B  = 3'd1;
  localparam logic [2:0] REG_AB = 3'd2;
  localparam logic [2:0] REG_C  = 3'd3;
  localparam logic [2:0] REG_AC = 3'd4;
  localparam logic [2:0] REG_BC = 3'd5;
  localparam logic [2:0] REG_IN = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic [2:0]           region;
    logic                 degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [SW-1:0] d1;
    logic signed [SW-1:0] d2;
    logic signed [SW-1:0] d3;
    logic signed [SW-1:0] d4;
    logic signed [SW-1:0] d5;
    logic signed [SW-1:0] d6;
    logic signed [SW-1:0] k;
    logic signed [SW-1:0] cab;
    logic signed [SW-1:0] cac;
    logic signed [SW-1:0] cbc;
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
    logic signed [DW-1:0] acx;
    logic signed [DW-1:0] acy;
    logic signed [DW-1:0] bcx;
    logic signed [DW-1:0] bcy;
    in_item_t             pt;
  } front_t;

  typedef struct packed {
    logic [NW-1:0]        num;
    logic [NW-1:0]        den;
    logic [MW-1:0]        mx;
    logic [MW-1:0]        my;
    logic                 negx;
    logic                 negy;
    logic signed [CW-1:0] basex;
    logic signed [CW-1:0] basey;
    logic [2:0]           region;
    logic                 deg;
  } sel_t;

  typedef struct packed {
    logic [DVW-1:0]       rx;
    logic [DVW-1:0]       ry;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
    logic [NW:0]          dd;
    logic                 negx;
    logic                 negy;
    logic signed [CW-1:0] basex;
    logic signed [CW-1:0] basey;
    logic [2:0]           region;
    logic                 deg;
  } div_t;

endpackage

// File: hdl/tcp_front.sv
`timescale 1ns / 1ps
// Differences, products and dot/cross sums over three register stages.
module tcp_front import tcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     valid_o,
  output front_t   res_o
);

  localparam int NPROD = 20;

  typedef struct packed {
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
    logic signed [DW-1:0] acx;
    logic signed [DW-1:0] acy;
    logic signed [DW-1:0] bcx;
    logic signed [DW-1:0] bcy;
    logic signed [DW-1:0] apx;
    logic signed [DW-1:0] apy;
    logic signed [DW-1:0] bpx;
    logic signed [DW-1:0] bpy;
    logic signed [DW-1:0] cpx;
    logic signed [DW-1:0] cpy;
    in_item_t             pt;
  } diff_t;

  diff_t                s1_d, s1_q, s2_q;
  logic signed [DW-1:0] opa [NPROD];
  logic signed [DW-1:0] opb [NPROD];
  logic signed [PW-1:0] prod_d [NPROD];
  logic signed [PW-1:0] prod_q [NPROD];
  front_t               s3_d, s3_q;
  logic [2:0]           vld_q;

  always_comb begin
    s1_d.pt  = item_i;
    s1_d.abx = DW'(item_i.bx) - DW'(item_i.ax);
    s1_d.aby = DW'(item_i.by) - DW'(item_i.ay);
    s1_d.acx = DW'(item_i.cx) - DW'(item_i.ax);
    s1_d.acy = DW'(item_i.cy) - DW'(item_i.ay);
    s1_d.bcx = DW'(item_i.cx) - DW'(item_i.bx);
    s1_d.bcy = DW'(item_i.cy) - DW'(item_i.by);
    s1_d.apx = DW'(item_i.px) - DW'(item_i.ax);
    s1_d.apy = DW'(item_i.py) - DW'(item_i.ay);
    s1_d.bpx = DW'(item_i.px) - DW'(item_i.bx);
    s1_d.bpy = DW'(item_i.py) - DW'(item_i.by);
    s1_d.cpx = DW'(item_i.px) - DW'(item_i.cx);
    s1_d.cpy = DW'(item_i.py) - DW'(item_i.cy);
  end

  // Operand pairs of the twenty products; pairs are summed or differenced below.
  always_comb begin
    opa[0]  = s1_q.abx; opb[0]  = s1_q.apx;
    opa[1]  = s1_q.aby; opb[1]  = s1_q.apy;
    opa[2]  = s1_q.acx; opb[2]  = s1_q.apx;
    opa[3]  = s1_q.acy; opb[3]  = s1_q.apy;
    opa[4]  = s1_q.abx; opb[4]  = s1_q.bpx;
    opa[5]  = s1_q.aby; opb[5]  = s1_q.bpy;
    opa[6]  = s1_q.acx; opb[6]  = s1_q.bpx;
    opa[7]  = s1_q.acy; opb[7]  = s1_q.bpy;
    opa[8]  = s1_q.abx; opb[8]  = s1_q.cpx;
    opa[9]  = s1_q.aby; opb[9]  = s1_q.cpy;
    opa[10] = s1_q.acx; opb[10] = s1_q.cpx;
    opa[11] = s1_q.acy; opb[11] = s1_q.cpy;
    opa[12] = s1_q.abx; opb[12] = s1_q.acy;
    opa[13] = s1_q.aby; opb[13] = s1_q.acx;
    opa[14] = s1_q.abx; opb[14] = s1_q.apy;
    opa[15] = s1_q.aby; opb[15] = s1_q.apx;
    opa[16] = s1_q.apx; opb[16] = s1_q.acy;
    opa[17] = s1_q.apy; opb[17] = s1_q.acx;
    opa[18] = s1_q.bcx; opb[18] = s1_q.bpy;
    opa[19] = s1_q.bcy; opb[19] = s1_q.bpx;
  end

  for (genvar i = 0; i < NPROD; i++) begin : g_mul
    assign prod_d[i] = PW'(opa[i]) * PW'(opb[i]);
  end

  always_comb begin
    s3_d.d1  = SW'(prod_q[0])  + SW'(prod_q[1]);
    s3_d.d2  = SW'(prod_q[2])  + SW'(prod_q[3]);
    s3_d.d3  = SW'(prod_q[4])  + SW'(prod_q[5]);
    s3_d.d4  = SW'(prod_q[6])  + SW'(prod_q[7]);
    s3_d.d5  = SW'(prod_q[8])  + SW'(prod_q[9]);
    s3_d.d6  = SW'(prod_q[10]) + SW'(prod_q[11]);
    s3_d.k   = SW'(prod_q[12]) - SW'(prod_q[13]);
    s3_d.cab = SW'(prod_q[14]) - SW'(prod_q[15]);
    s3_d.cac = SW'(prod_q[16]) - SW'(prod_q[17]);
    s3_d.cbc = SW'(prod_q[18]) - SW'(prod_q[19]);
    s3_d.abx = s2_q.abx;
    s3_d.aby = s2_q.aby;
    s3_d.acx = s2_q.acx;
    s3_d.acy = s2_q.acy;
    s3_d.bcx = s2_q.bcx;
    s3_d.bcy = s2_q.bcy;
    s3_d.pt  = s2_q.pt;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int i = 0; i < NPROD; i++) begin
        prod_q[i] <= prod_d[i];
      end
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = s3_q;

endmodule

// File: hdl/tcp_select.sv
`timescale 1ns / 1ps
// Region tests in one stage, then the priority choice of the result case.
module tcp_select import tcp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  front_t fr_i,
  output logic   valid_o,
  output sel_t   sel_o
);

  typedef struct packed {
    logic                 c0;
    logic                 c1;
    logic                 c2;
    logic                 c3;
    logic                 c4;
    logic                 c5;
    logic                 deg5;
    logic                 deg6;
    logic signed [SW-1:0] d1;
    logic signed [SW-1:0] d2;
    logic signed [SW-1:0] e1;
    logic signed [SW-1:0] den_ab;
    logic signed [SW-1:0] den_ac;
    logic signed [SW-1:0] den_bc;
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
    logic signed [DW-1:0] acx;
    logic signed [DW-1:0] acy;
    logic signed [DW-1:0] bcx;
    logic signed [DW-1:0] bcy;
    in_item_t             pt;
  } cond_t;

  cond_t                cond_d, cond_q;
  sel_t                 sel_d, sel_q;
  logic signed [SW-1:0] e2;
  logic [1:0]           vld_q;

  function automatic logic is_neg(input logic signed [SW-1:0] v);
    return v[SW-1];
  endfunction

  function automatic logic is_le0(input logic signed [SW-1:0] v);
    return v[SW-1] || (v == '0);
  endfunction

  function automatic logic is_pos(input logic signed [SW-1:0] v);
    return !v[SW-1] && (v != '0);
  endfunction

  // True when the sign of k times the sign of v is not positive.
  function automatic logic side_ok(input logic signed [SW-1:0] k,
                                   input logic signed [SW-1:0] v);
    return !((is_pos(k) && is_pos(v)) || (is_neg(k) && is_neg(v)));
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = v[DW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  always_comb begin
    cond_d.e1     = fr_i.d4 - fr_i.d3;
    e2            = fr_i.d5 - fr_i.d6;
    cond_d.den_ab = fr_i.d1 - fr_i.d3;
    cond_d.den_ac = fr_i.d2 - fr_i.d6;
    cond_d.den_bc = fr_i.d4 - fr_i.d3 + fr_i.d5 - fr_i.d6;
    cond_d.c0     = is_le0(fr_i.d1) && is_le0(fr_i.d2);
    cond_d.c1     = !is_neg(fr_i.d3) && is_le0(cond_d.e1);
    cond_d.c2     = side_ok(fr_i.k, fr_i.cab) && !is_neg(fr_i.d1) && is_neg(fr_i.d3);
    cond_d.c3     = !is_neg(fr_i.d6) && is_le0(e2);
    cond_d.c4     = side_ok(fr_i.k, fr_i.cac) && is_pos(fr_i.d2) && is_neg(fr_i.d6);
    cond_d.c5     = side_ok(fr_i.k, fr_i.cbc) && !is_neg(cond_d.e1) && !is_neg(e2);
    cond_d.deg5   = (cond_d.den_bc == '0);
    cond_d.deg6   = (fr_i.k == '0);
    cond_d.d1     = fr_i.d1;
    cond_d.d2     = fr_i.d2;
    cond_d.abx    = fr_i.abx;
    cond_d.aby    = fr_i.aby;
    cond_d.acx    = fr_i.acx;
    cond_d.acy    = fr_i.acy;
    cond_d.bcx    = fr_i.bcx;
    cond_d.bcy    = fr_i.bcy;
    cond_d.pt     = fr_i.pt;
  end

  // Cases without interpolation keep a zero numerator over a unit denominator,
  // so the divider returns zero and the result is the base point.
  always_comb begin
    sel_d        = '0;
    sel_d.den    = NW'(1);
    sel_d.basex  = cond_q.pt.ax;
    sel_d.basey  = cond_q.pt.ay;
    sel_d.region = REG_A;
    priority if (cond_q.c0) begin
      sel_d.region = REG_A;
    end else if (cond_q.c1) begin
      sel_d.region = REG_B;
      sel_d.basex  = cond_q.pt.bx;
      sel_d.basey  = cond_q.pt.by;
    end else if (cond_q.c2) begin
      sel_d.region = REG_AB;
      sel_d.num    = cond_q.d1[NW-1:0];
      sel_d.den    = cond_q.den_ab[NW-1:0];
      sel_d.mx     = mag(cond_q.abx);
      sel_d.my     = mag(cond_q.aby);
      sel_d.negx   = cond_q.abx[DW-1];
      sel_d.negy   = cond_q.aby[DW-1];
    end else if (cond_q.c3) begin
      sel_d.region = REG_C;
      sel_d.basex  = cond_q.pt.cx;
      sel_d.basey  = cond_q.pt.cy;
    end else if (cond_q.c4) begin
      sel_d.region = REG_AC;
      sel_d.num    = cond_q.d2[NW-1:0];
      sel_d.den    = cond_q.den_ac[NW-1:0];
      sel_d.mx     = mag(cond_q.acx);
      sel_d.my     = mag(cond_q.acy);
      sel_d.negx   = cond_q.acx[DW-1];
      sel_d.negy   = cond_q.acy[DW-1];
    end else if (cond_q.c5) begin
      sel_d.region = REG_BC;
      if (cond_q.deg5) begin
        sel_d.deg = 1'b1;
      end else begin
        sel_d.basex = cond_q.pt.bx;
        sel_d.basey = cond_q.pt.by;
        sel_d.num   = cond_q.e1[NW-1:0];
        sel_d.den   = cond_q.den_bc[NW-1:0];
        sel_d.mx    = mag(cond_q.bcx);
        sel_d.my    = mag(cond_q.bcy);
        sel_d.negx  = cond_q.bcx[DW-1];
        sel_d.negy  = cond_q.bcy[DW-1];
      end
    end else begin
      sel_d.region = REG_IN;
      if (cond_q.deg6) begin
        sel_d.deg = 1'b1;
      end else begin
        sel_d.basex = cond_q.pt.px;
        sel_d.basey = cond_q.pt.py;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cond_q <= cond_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign sel_o   = sel_q;

endmodule

// File: hdl/tcp_div_stage.sv
`timescale 1ns / 1ps
// One restoring division step for both coordinates: quotient bit BIT.
module tcp_div_stage import tcp_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t item_i,
  output logic valid_o,
  output div_t item_o
);

  logic [DVW-1:0] sub;
  div_t           nxt;
  div_t           item_q;
  logic           valid_q;

  always_comb begin
    sub = DVW'(item_i.dd) << BIT;
    nxt = item_i;
    if (item_i.rx >= sub) begin
      nxt.rx      = item_i.rx - sub;
      nxt.qx[BIT] = 1'b1;
    end
    if (item_i.ry >= sub) begin
      nxt.ry      = item_i.ry - sub;
      nxt.qy[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/tcp_lerp.sv
`timescale 1ns / 1ps
// Rounded scaling comp * num / den: partial products, dividend set-up and a
// pipelined restoring divider with one quotient bit per stage.
module tcp_lerp import tcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sel_t sel_i,
  output logic valid_o,
  output div_t div_o
);

  typedef struct packed {
    logic [NCH-1:0][PPW-1:0] ppx;
    logic [NCH-1:0][PPW-1:0] ppy;
    logic [NW-1:0]           den;
    logic                    negx;
    logic                    negy;
    logic signed [CW-1:0]    basex;
    logic signed [CW-1:0]    basey;
    logic [2:0]              region;
    logic                    deg;
  } pp_t;

  pp_t                 pp_d, pp_q;
  logic [NCH*KW-1:0]   num_ext;
  logic [DVW-1:0]      sumx, sumy;
  div_t                dv_d;
  div_t                chain [QW+1];
  logic [QW:0]         chain_vld;
  logic [1:0]          vld_q;

  always_comb begin
    num_ext = (NCH*KW)'(sel_i.num);
    for (int i = 0; i < NCH; i++) begin
      pp_d.ppx[i] = PPW'(num_ext[i*KW +: KW]) * PPW'(sel_i.mx);
      pp_d.ppy[i] = PPW'(num_ext[i*KW +: KW]) * PPW'(sel_i.my);
    end
    pp_d.den    = sel_i.den;
    pp_d.negx   = sel_i.negx;
    pp_d.negy   = sel_i.negy;
    pp_d.basex  = sel_i.basex;
    pp_d.basey  = sel_i.basey;
    pp_d.region = sel_i.region;
    pp_d.deg    = sel_i.deg;
  end

  // Dividend 2*num*m + den over divisor 2*den rounds half away from zero.
  always_comb begin
    sumx = '0;
    sumy = '0;
    for (int i = 0; i < NCH; i++) begin
      sumx = sumx + (DVW'(pp_q.ppx[i]) << (i*KW));
      sumy = sumy + (DVW'(pp_q.ppy[i]) << (i*KW));
    end
    dv_d.rx     = (sumx << 1) + DVW'(pp_q.den);
    dv_d.ry     = (sumy << 1) + DVW'(pp_q.den);
    dv_d.qx     = '0;
    dv_d.qy     = '0;
    dv_d.dd     = {pp_q.den, 1'b0};
    dv_d.negx   = pp_q.negx;
    dv_d.negy   = pp_q.negy;
    dv_d.basex  = pp_q.basex;
    dv_d.basey  = pp_q.basey;
    dv_d.region = pp_q.region;
    dv_d.deg    = pp_q.deg;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q     <= pp_d;
      chain[0] <= dv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign chain_vld[0] = vld_q[1];

  for (genvar i = 0; i < QW; i++) begin : g_div
    tcp_div_stage #(
      .BIT(QW - 1 - i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(chain_vld[i]),
      .item_i (chain[i]),
      .valid_o(chain_vld[i+1]),
      .item_o (chain[i+1])
    );
  end

  assign valid_o = chain_vld[QW];
  assign div_o   = chain[QW];

endmodule

// File: hdl/triangle_closest_point.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle when not stalled; every stage is a register, the longest
// being a 33x33 multiply or one wide compare and subtract of the divider.
// Reset: asynchronous, active low; clears all valid bits and the output valid.
// Stalls: the whole pipeline holds while the output item waits to be taken.
`include "assert_macros.svh"
module triangle_closest_point import tcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // The pipeline is split as follows:
  //   three stages of differences, products and dot/cross sums (front),
  //   two stages of region tests and case selection (select),
  //   two stages of partial products and dividend set-up, then one stage per
  //   quotient bit of a restoring divider (lerp),
  //   and a final stage here that adds the signed offset to the base corner,
  //   saturates to the coordinate range and holds the output item.
  // All stages share one advance enable. A stage moves whenever the output
  // register is empty or its item is being taken, so a stall loses nothing.

  localparam logic signed [CW+1:0] SMAX = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] SMIN = {3'b111, {(CW-1){1'b0}}};

  logic                 pipe_en;
  logic                 front_valid, sel_valid, lerp_valid;
  front_t               front_res;
  sel_t                 sel_res;
  div_t                 lerp_res;
  logic signed [CW+1:0] sumx, sumy;
  out_item_t            out_d, out_q;
  logic                 out_valid_q;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    t = v;
    if (v > SMAX) begin
      t = SMAX;
    end else if (v < SMIN) begin
      t = SMIN;
    end
    return t[CW-1:0];
  endfunction

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  tcp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(in_valid_i),
    .item_i (in_item_i),
    .valid_o(front_valid),
    .res_o  (front_res)
  );

  tcp_select u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(front_valid),
    .fr_i   (front_res),
    .valid_o(sel_valid),
    .sel_o  (sel_res)
  );

  tcp_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(sel_valid),
    .sel_i  (sel_res),
    .valid_o(lerp_valid),
    .div_o  (lerp_res)
  );

  // The quotient is a magnitude; the edge component's sign is applied here.
  always_comb begin
    sumx = (CW+2)'(lerp_res.basex) + (lerp_res.negx ? -$signed({2'b00, lerp_res.qx})
                                                    : $signed({2'b00, lerp_res.qx}));
    sumy = (CW+2)'(lerp_res.basey) + (lerp_res.negy ? -$signed({2'b00, lerp_res.qy})
                                                    : $signed({2'b00, lerp_res.qy}));
    out_d.qx         = sat(sumx);
    out_d.qy         = sat(sumy);
    out_d.region     = lerp_res.region;
    out_d.degenerate = lerp_res.deg;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= lerp_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Only the bc edge and interior cases can flag a zero divisor.
  `TCP_ASSERT(a_deg_region, clk_i, rst_ni, out_valid_o && out_item_o.degenerate |-> (out_item_o.region == REG_BC || out_item_o.region == REG_IN), "degenerate flag outside bc edge or interior")
  `TCP_ASSERT_NEVER(a_region_range, clk_i, rst_ni, out_valid_o && (out_item_o.region > REG_IN), "region code out of range")
  // A held output must freeze the valid bit of the last divider stage.
  `TCP_ASSERT(a_stall_freeze, clk_i, rst_ni, !pipe_en |=> $stable(lerp_valid), "pipeline moved during a stall")

endmodule

// File: dv/triangle_closest_point_tb.sv
`timescale 1ns / 1ps
module triangle_closest_point_tb;
  import tcp_pkg::*;

  // Wide enough for every exact product, sum and rounding dividend.
  typedef logic signed [159:0] wide_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  out_item_t expected_q[$];
  int        n_errors;
  int        n_accepted;
  int        n_sent;
  int        hold_cycles;

  triangle_closest_point DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int sgn(wide_t v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic wide_t dot2(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
    return x1 * x2 + y1 * y2;
  endfunction

  function automatic wide_t cross2(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
    return x1 * y2 - y1 * x2;
  endfunction

  // Rounded comp * num / den, ties away from zero; zero if den <= 0 or num < 0.
  function automatic wide_t lerp_offset(wide_t comp, wide_t num, wide_t den);
    wide_t mag;
    wide_t quo;
    if (den <= 0 || num < 0) return 0;
    mag = (comp < 0) ? -comp : comp;
    quo = (2 * num * mag + den) / (2 * den);
    return (comp < 0) ? -quo : quo;
  endfunction

  function automatic logic signed [CW-1:0] sat32(wide_t v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[CW-1:0];
  endfunction

  // Voronoi-region search for the closest point on the triangle.
  function automatic out_item_t closest_point(in_item_t it);
    wide_t ax, ay, bx, by, cx, cy, px, py;
    wide_t abx, aby, acx, acy, bcx, bcy, apx, apy, bpx, bpy, cpx, cpy;
    wide_t d1, d2, d3, d4, d5, d6, e1, e2, den, qx, qy;
    int sk;
    out_item_t r;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
    cx = it.cx; cy = it.cy; px = it.px; py = it.py;
    abx = bx - ax; aby = by - ay; acx = cx - ax; acy = cy - ay;
    bcx = cx - bx; bcy = cy - by;
    apx = px - ax; apy = py - ay; bpx = px - bx; bpy = py - by;
    cpx = px - cx; cpy = py - cy;
    qx = ax; qy = ay;
    r.degenerate = 1'b0;
    d1 = dot2(abx, aby, apx, apy);
    d2 = dot2(acx, acy, apx, apy);
    d3 = dot2(abx, aby, bpx, bpy);
    d4 = dot2(acx, acy, bpx, bpy);
    d5 = dot2(abx, aby, cpx, cpy);
    d6 = dot2(acx, acy, cpx, cpy);
    e1 = d4 - d3;
    e2 = d5 - d6;
    sk = sgn(cross2(abx, aby, acx, acy));
    if (d1 <= 0 && d2 <= 0) begin
      r.region = REG_A;
    end else if (d3 >= 0 && e1 <= 0) begin
      qx = bx; qy = by; r.region = REG_B;
    end else if (sk * sgn(cross2(abx, aby, apx, apy)) <= 0 && d1 >= 0 && d3 < 0) begin
      den = d1 - d3;
      qx = ax + lerp_offset(abx, d1, den);
      qy = ay + lerp_offset(aby, d1, den);
      r.region = REG_AB;
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      qx = cx; qy = cy; r.region = REG_C;
    end else if (sk * sgn(cross2(apx, apy, acx, acy)) <= 0 && d2 > 0 && d6 < 0) begin
      den = d2 - d6;
      qx = ax + lerp_offset(acx, d2, den);
      qy = ay + lerp_offset(acy, d2, den);
      r.region = REG_AC;
    end else if (sk * sgn(cross2(bcx, bcy, bpx, bpy)) <= 0 && e1 >= 0 && e2 >= 0) begin
      den = e1 + e2;
      r.region = REG_BC;
      if (den == 0) begin
        r.degenerate = 1'b1;
      end else begin
        qx = bx + lerp_offset(bcx, e1, den);
        qy = by + lerp_offset(bcy, e1, den);
      end
    end else begin
      r.region = REG_IN;
      if (sk == 0) begin
        r.degenerate = 1'b1;
      end else begin
        qx = px; qy = py;
      end
    end
    r.qx = sat32(qx);
    r.qy = sat32(qy);
    return r;
  endfunction

  // Input acceptances are seen with pre-edge values, so the expected result
  // is queued at exactly the edge where the item enters the block.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_q.push_back(closest_point(in_item_i));
      n_accepted <= n_accepted + 1;
    end
  end

  // Result checker: every accepted result must match the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        n_errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_item_o.qx !== exp_item.qx) begin
          $display("%0t: qx expected %h actual %h", $time, exp_item.qx, out_item_o.qx);
          n_errors++;
        end
        if (out_item_o.qy !== exp_item.qy) begin
          $display("%0t: qy expected %h actual %h", $time, exp_item.qy, out_item_o.qy);
          n_errors++;
        end
        if (out_item_o.region !== exp_item.region) begin
          $display("%0t: region expected %0d actual %0d", $time, exp_item.region,
                   out_item_o.region);
          n_errors++;
        end
        if (out_item_o.degenerate !== exp_item.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_item.degenerate,
                   out_item_o.degenerate);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random stalls, with an occasional long hold-off requested by a test.
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (r < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (r < 97) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one item, hold it until accepted, then maybe leave a gap.
  task automatic send_item(in_item_t it, bit no_gap = 1'b0);
    int r;
    int gap;
    in_valid_i = 1'b1;
    in_item_i  = it;
    n_sent++;
    do @(negedge clk_i); while (n_accepted != n_sent);
    r = $urandom_range(0, 99);
    gap = (no_gap || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic in_item_t make_item(int ax, int ay, int bx, int by,
                                         int cx, int cy, int px, int py);
    in_item_t it;
    it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
    it.cx = cx; it.cy = cy; it.px = px; it.py = py;
    return it;
  endfunction

  // Small coordinates reach every region often; the shift spreads magnitudes.
  function automatic int small_coord(int sh);
    return ($signed($urandom_range(0, 64)) - 32) <<< sh;
  endfunction

  task automatic test_directed();
    int mx;
    int mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));                        // all one point
    send_item(make_item(5, 5, 5, 5, 5, 5, 9, -3));                       // point triangle
    send_item(make_item(mn, mn, mx, mn, mn, mx, mx, mx));                // extremes, edge bc
    send_item(make_item(mx, mx, mn, mx, mx, mn, mn, mn));
    send_item(make_item(mn, mn, mx, mn, mn, mx, mn, mn));                // p on corner a
    send_item(make_item(mn, mn, mx, mn, mn, mx, mx, mn));                // p on corner b
    send_item(make_item(mn, mn, mx, mn, mn, mx, mn, mx));                // p on corner c
    send_item(make_item(mn, mn, mx, mx, mx, mn, 0, mn));
    send_item(make_item(0, 0, 65536, 0, 0, 65536, -65536, -65536));     // corner a region
    send_item(make_item(0, 0, 65536, 0, 0, 65536, 131072, -100));       // corner b region
    send_item(make_item(0, 0, 65536, 0, 0, 65536, -100, 131072));       // corner c region
    send_item(make_item(0, 0, 65536, 0, 0, 65536, 30000, -5000));       // edge ab
    send_item(make_item(0, 0, 65536, 0, 0, 65536, -5000, 30000));       // edge ac
    send_item(make_item(0, 0, 65536, 0, 0, 65536, 50000, 50000));       // edge bc
    send_item(make_item(0, 0, 65536, 0, 0, 65536, 10000, 10000));       // interior
    send_item(make_item(0, 0, 65536, 0, 0, 65536, 16385, -3));          // rounding tie area
    send_item(make_item(0, 0, 2, 0, 4, 0, 3, 1));                       // collinear corners
    send_item(make_item(0, 0, 4, 0, 2, 0, 2, 1));
    send_item(make_item(0, 0, 4, 4, 2, 2, 1, 3));
    send_item(make_item(3, 3, 0, 0, 0, 0, 1, 5));                       // b equals c
    send_item(make_item(0, 0, 1, 2, 3, 1, -1, -1));
  endtask

  task automatic test_random_small(int count);
    int sh;
    repeat (count) begin
      sh = $urandom_range(0, 16);
      send_item(make_item(small_coord(sh), small_coord(sh), small_coord(sh),
                          small_coord(sh), small_coord(sh), small_coord(sh),
                          small_coord(sh), small_coord(sh)));
    end
  endtask

  task automatic test_random_full(int count);
    repeat (count) begin
      send_item(make_item($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  // Collinear or coincident corners exercise both degenerate outcomes.
  task automatic test_collinear(int count);
    int ax, ay, dx, dy, t, s;
    repeat (count) begin
      ax = small_coord(4);
      ay = small_coord(4);
      dx = $signed($urandom_range(0, 6)) - 3;
      dy = $signed($urandom_range(0, 6)) - 3;
      t = $signed($urandom_range(0, 8)) - 4;
      s = $signed($urandom_range(0, 8)) - 4;
      send_item(make_item(ax, ay, ax + t * dx, ay + t * dy, ax + s * dx, ay + s * dy,
                          ax + small_coord(2), ay + small_coord(2)));
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // pipeline fills and the block must drop its input ready.
  task automatic test_backpressure(int count);
    hold_cycles = 200;
    repeat (count) begin
      send_item(make_item($urandom, $urandom, $urandom, $urandom,
                          small_coord(8), small_coord(8), $urandom, $urandom), 1'b1);
    end
  endtask

  initial begin
    n_errors    = 0;
    n_accepted  = 0;
    n_sent      = 0;
    hold_cycles = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_small(700);
    test_collinear(250);
    test_random_full(300);
    test_backpressure(150);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/tcp_pkg.sv
hdl/tcp_front.sv
hdl/tcp_select.sv
hdl/tcp_div_stage.sv
hdl/tcp_lerp.sv
hdl/triangle_closest_point.sv
dv/triangle_closest_point_tb.sv
